[rtl/sstw_pkg.sv]
// ----------------------------------------------------------------------------
// sstw_pkg: shared types, constants and font table of the text writer
// Digit position sizing, control/status structs and the segment font lookup.
// ----------------------------------------------------------------------------
package sstw_pkg;

   // default display length and digit position width
   localparam int NUM_DIGITS_DEF = 6;
   localparam int POS_W          = 4;

   localparam logic [7:0] DP_BIT    = 8'h80;
   localparam logic [7:0] DOT_CODE  = 8'h2E;
   localparam logic [7:0] BLANK_SEG = 8'h00;

   // controller to datapath commands
   typedef struct packed {
      logic accept_char;   // take a character beat
      logic flush_emit;    // write pending glyph or blank at current position
      logic clear_state;   // return position and pending register to reset
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pos_full;      // every digit written
      logic pos_last;      // current position is the rightmost digit
      logic slot_free;     // output register can take a beat this cycle
   } ctl_stat_type;

   // segment byte for a character, zero when not in the font
   function automatic logic [7:0] glyph(input logic [7:0] code);
      logic [7:0] seg;
      begin
         case (code)
            "0": seg = 8'h7E;  "1": seg = 8'h30;  "2": seg = 8'h6D;
            "3": seg = 8'h79;  "4": seg = 8'h33;  "5": seg = 8'h5B;
            "6": seg = 8'h5F;  "7": seg = 8'h70;  "8": seg = 8'h7F;
            "9": seg = 8'h7B;  "A": seg = 8'h77;  "b": seg = 8'h1F;
            "B": seg = 8'h1F;  "C": seg = 8'h4E;  "c": seg = 8'h0D;
            "d": seg = 8'h3D;  "D": seg = 8'h3D;  "E": seg = 8'h4F;
            "F": seg = 8'h47;  "G": seg = 8'h5E;  "H": seg = 8'h37;
            "h": seg = 8'h17;  "I": seg = 8'h30;  "i": seg = 8'h10;
            "J": seg = 8'h3C;  "K": seg = 8'h37;  "L": seg = 8'h0E;
            "M": seg = 8'h00;  "n": seg = 8'h15;  "O": seg = 8'h7E;
            "o": seg = 8'h1D;  "P": seg = 8'h67;  "Q": seg = 8'h73;
            "q": seg = 8'h73;  "r": seg = 8'h05;  "S": seg = 8'h5B;
            "t": seg = 8'h0F;  "U": seg = 8'h3E;  "u": seg = 8'h1C;
            "V": seg = 8'h3E;  "W": seg = 8'h3E;  "X": seg = 8'h37;
            "Y": seg = 8'h3B;  "y": seg = 8'h3B;  "Z": seg = 8'h6D;
            "z": seg = 8'h6D;  "-": seg = 8'h01;  "_": seg = 8'h08;
            " ": seg = 8'h00;  "=": seg = 8'h09;
            default: seg = BLANK_SEG;
         endcase
         return seg;
      end
   endfunction

endpackage

[rtl/sstw_ctrl.sv]
// ----------------------------------------------------------------------------
// sstw_ctrl: sequencing controller of the text writer
// Takes character beats in RUN; FLUSH writes any pending glyph, then blanks.
// ----------------------------------------------------------------------------
module sstw_ctrl
   import sstw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_end,
   output logic         req_tready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_tready = (state_ff == ST_RUN) && stat.slot_free;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd.accept_char = 1'b0;
      cmd.flush_emit  = 1'b0;
      cmd.clear_state = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (req_tvalid && req_tready) begin
               if (req_end) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.accept_char = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.pos_full) begin
               // display was already full: nothing left to write
               cmd.clear_state = 1'b1;
               state_in        = ST_RUN;
            end else if (stat.slot_free) begin
               cmd.flush_emit = 1'b1;
               if (stat.pos_last) begin
                  cmd.clear_state = 1'b1;
                  state_in        = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/sstw_datapath.sv]
// ----------------------------------------------------------------------------
// sstw_datapath: pending character, digit position and output register
// Looks up segments, merges a following dot and drives the result beats.
// ----------------------------------------------------------------------------
module sstw_datapath
   import sstw_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   char_code,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [3:0]   reg_addr,
   output logic [7:0]   seg_data,
   output logic         last_write
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);
   localparam logic [POS_W-1:0] FULL_POS = POS_W'(NUM_DIGITS);

   logic [7:0]       pend_char_ff, pend_char_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   logic [3:0]       out_addr_ff, out_addr_in;
   logic [7:0]       out_seg_ff, out_seg_in;
   logic             out_last_ff, out_last_in;
   logic             load;
   logic             is_dot;
   logic [7:0]       pend_seg;

   assign stat.pos_full  = (pos_ff >= FULL_POS);
   assign stat.pos_last  = (pos_ff == LAST_POS);
   assign stat.slot_free = !out_valid_ff || rsp_tready;

   assign is_dot   = (char_code == DOT_CODE);
   assign pend_seg = glyph(pend_char_ff);

   // state update and output load
   always_comb begin
      pend_char_in  = pend_char_ff;
      pend_valid_in = pend_valid_ff;
      pos_in        = pos_ff;
      load          = 1'b0;
      out_seg_in    = out_seg_ff;
      out_addr_in   = 4'(NUM_DIGITS) - 4'(pos_ff);
      out_last_in   = stat.pos_last;

      if (cmd.accept_char) begin
         if (stat.pos_full) begin
            // past the last digit: drop
            pend_valid_in = 1'b0;
         end else if (pend_valid_ff) begin
            load          = 1'b1;
            out_seg_in    = is_dot ? (pend_seg | DP_BIT) : pend_seg;
            pos_in        = pos_ff + 1'b1;
            pend_valid_in = !is_dot && !stat.pos_last;
            pend_char_in  = char_code;
         end else begin
            pend_char_in  = char_code;
            pend_valid_in = 1'b1;
         end
      end

      if (cmd.flush_emit) begin
         load          = 1'b1;
         out_seg_in    = pend_valid_ff ? pend_seg : BLANK_SEG;
         pos_in        = pos_ff + 1'b1;
         pend_valid_in = 1'b0;
      end

      if (cmd.clear_state) begin
         pos_in        = '0;
         pend_valid_in = 1'b0;
         pend_char_in  = 8'h00;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pos_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pos_ff        <= pos_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_char_ff <= pend_char_in;
      if (load) begin
         out_addr_ff <= out_addr_in;
         out_seg_ff  <= out_seg_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign reg_addr   = out_addr_ff;
   assign seg_data   = out_seg_ff;
   assign last_write = out_last_ff;

endmodule

[rtl/seven_segment_text_writer_unit.sv]
// ----------------------------------------------------------------------------
// seven_segment_text_writer_unit: text to seven-segment digit writes
// Turns a character stream into digit register writes, merging dots.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                       | tuser / tlast
//  req_     | in        | [7:0] char_code             | tuser[0] end_of_text
//  rsp_     | out       | [3:0] reg_addr [11:4] seg   | tlast = last_write
//
//  A taken character beat causes at most one write. An end beat starts a
//  fill of one write per cycle, while the output register has room, for
//  every remaining digit, none when the display was already full; no request
//  is taken during the fill. A single output register decouples the sides.
//  Reset is synchronous; it empties the output register and pending char.
// ----------------------------------------------------------------------------
module seven_segment_text_writer_unit
   import sstw_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [0:0]  req_tuser,   // [0] end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] reg_addr, [11:4] seg_data, rest 0
   output logic        rsp_tlast
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;
   logic [3:0]   reg_addr;
   logic [7:0]   seg_data;

   sstw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_end    (req_tuser[0]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sstw_datapath #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .char_code  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .reg_addr   (reg_addr),
      .seg_data   (seg_data),
      .last_write (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, seg_data, reg_addr};

   // an end beat always starts a fill during which no request is taken
   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("request taken right after end beat");

   // request is only taken when the output register has room
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!rsp_tvalid || rsp_tready))
      else $error("request taken with output register blocked");

   // written address stays within the display
   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] >= 4'd1) && (rsp_tdata[3:0] <= 4'(NUM_DIGITS)))
      else $error("digit address out of range");

   // fill state never coexists with a command to take a character
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_char |-> !cmd.flush_emit && !cmd.clear_state)
      else $error("conflicting datapath commands");

endmodule
